// File: rtl/core/scs1_pkg.sv
// Shared types, constants and key tables of the set 1 scancode decoder.
package scs1_pkg;

  // Ring geometry; one slot stays empty to tell full from empty.
  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CHAR_W     = 7;
  localparam int CODE_W     = 7;

  // Byte layout and reset values of the key code registers.
  localparam logic [7:0]        RELEASE_BIT     = 8'h80;
  localparam logic [CODE_W-1:0] CODE_MASK       = 7'h7F;
  localparam logic [CODE_W-1:0] LEFT_SHIFT_RST  = 7'd42;
  localparam logic [CODE_W-1:0] RIGHT_SHIFT_RST = 7'd54;
  localparam logic [CODE_W-1:0] CAPS_LOCK_RST   = 7'd58;
  localparam int                TABLE_SIZE      = 64;
  localparam int                TABLE_W         = $clog2(TABLE_SIZE);

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_SHIFT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_SHIFT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAPS_LOCK   = 2'd2;

  // Input item kinds.
  localparam logic FUNC_SCAN = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] scan_byte;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic              read_valid;
    logic              data_available;
    logic              char_dropped;
  } out_word_t;

  // Key code registers as one group.
  typedef struct packed {
    logic [CODE_W-1:0] left_shift;
    logic [CODE_W-1:0] right_shift;
    logic [CODE_W-1:0] caps_key;
  } key_cfg_t;

  // What one scancode byte does to the modifier flags and the ring.
  typedef struct packed {
    logic              shift_nxt;
    logic              caps_nxt;
    logic              push;
    logic [CHAR_W-1:0] ch;
  } key_act_t;

  // Unshifted characters by key code.
  localparam logic [CHAR_W-1:0] PLAIN_MAP [TABLE_SIZE] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Shifted characters by key code.
  localparam logic [CHAR_W-1:0] UPPER_MAP [TABLE_SIZE] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Ring pointer increment with wrap at the ring depth.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + PTR_W'(1);
    end
    return q;
  endfunction

endpackage

// File: rtl/core/scs1_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module scs1_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 7,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data is registered, appears in the cycle after the request and holds until the next one.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/scs1_keymap.sv
// Scancode interpretation: modifier tracking and character lookup.
module scs1_keymap (
  input  logic [7:0]        scan_byte,
  input  logic              shift_held,
  input  logic              caps_on,
  input  scs1_pkg::key_cfg_t key_cfg,
  output scs1_pkg::key_act_t act
);

  logic                             release_key;
  logic [scs1_pkg::CODE_W-1:0]      code;
  logic [scs1_pkg::CHAR_W-1:0]      ch;
  logic                             is_shift;
  logic                             is_caps;
  logic                             in_table;

  assign release_key = (scan_byte & scs1_pkg::RELEASE_BIT) != 8'h00;
  assign code        = scan_byte[scs1_pkg::CODE_W-1:0] & scs1_pkg::CODE_MASK;
  assign is_shift    = (code == key_cfg.left_shift) || (code == key_cfg.right_shift);
  assign is_caps     = (code == key_cfg.caps_key);
  assign in_table    = code < scs1_pkg::CODE_W'(scs1_pkg::TABLE_SIZE);

  // Table select follows shift XOR caps.
  always_comb begin
    if (shift_held != caps_on) begin
      ch = scs1_pkg::UPPER_MAP[code[scs1_pkg::TABLE_W-1:0]];
    end else begin
      ch = scs1_pkg::PLAIN_MAP[code[scs1_pkg::TABLE_W-1:0]];
    end
  end

  // Shift wins over caps lock when both codes match; releases push nothing.
  always_comb begin
    act.shift_nxt = shift_held;
    act.caps_nxt  = caps_on;
    act.push      = 1'b0;
    act.ch        = ch;
    if (is_shift) begin
      act.shift_nxt = !release_key;
    end else if (is_caps && !release_key) begin
      act.caps_nxt = !caps_on;
    end else if (!release_key && in_table) begin
      act.push = ch != '0;
    end
  end

endmodule

// File: rtl/core/scancode_set1_decoder_fifo.sv
// Top level: set 1 scancode decoder feeding a character ring held in RAM.
//
//  Channel  Ports                               Moves
//  input    in_valid, in_stall, in_word          one scancode byte or read request
//  result   out_valid, out_stall, out_word       one result word per input word
//  config   cfg_we, cfg_addr, cfg_wdata          key code register writes
//
// One word is accepted per cycle while in_stall is low; its result passes through the read stage,
// where the ring RAM read is registered, and then through the output register.
// Pointers and modifier flags update at acceptance, so back-to-back reads and pushes
// never touch the same RAM entry in one cycle.
// Reset clears the pointers and the flags and loads the default key codes; the RAM is not cleared.
// A stalled output register keeps one more word in the read stage, after which
// in_stall rises until the output drains.
module scancode_set1_decoder_fifo (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  scs1_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output scs1_pkg::out_word_t                out_word,
  input  logic                               cfg_we,
  input  logic [scs1_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [scs1_pkg::CODE_W-1:0]        cfg_wdata
);

  scs1_pkg::key_cfg_t          key_cfg_r;
  logic                        shift_held_r, shift_held_nxt;
  logic                        caps_on_r, caps_on_nxt;
  logic [scs1_pkg::PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [scs1_pkg::PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;

  // Read stage: a result waiting for its RAM data.
  logic                        s1_valid_r;
  logic                        s1_read_valid_r;
  logic                        s1_avail_r;
  logic                        s1_dropped_r;

  logic                        out_valid_r;
  scs1_pkg::out_word_t         out_word_r;

  logic                        accept;
  logic                        s1_advance;
  logic                        is_read;
  logic                        read_hit;
  logic                        ring_full;
  logic                        do_push;
  logic                        dropped;
  scs1_pkg::key_act_t          act;
  logic [scs1_pkg::CHAR_W-1:0] rd_data;

  assign s1_advance = !out_valid_r || !out_stall;
  assign in_stall   = s1_valid_r && !s1_advance;
  assign accept     = in_valid && !in_stall;
  assign is_read    = in_word.func == scs1_pkg::FUNC_READ;

  scs1_keymap u_keymap (
    .scan_byte  (in_word.scan_byte),
    .shift_held (shift_held_r),
    .caps_on    (caps_on_r),
    .key_cfg    (key_cfg_r),
    .act        (act)
  );

  // Ring occupancy and pointer moves for the word being accepted.
  assign read_hit  = is_read && (rd_ptr_r != wr_ptr_r);
  assign ring_full = scs1_pkg::ring_next(wr_ptr_r) == rd_ptr_r;
  assign do_push   = !is_read && act.push && !ring_full;
  assign dropped   = !is_read && act.push && ring_full;

  always_comb begin
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    shift_held_nxt = shift_held_r;
    caps_on_nxt    = caps_on_r;
    if (accept) begin
      if (read_hit) begin
        rd_ptr_nxt = scs1_pkg::ring_next(rd_ptr_r);
      end
      if (!is_read) begin
        shift_held_nxt = act.shift_nxt;
        caps_on_nxt    = act.caps_nxt;
      end
      if (do_push) begin
        wr_ptr_nxt = scs1_pkg::ring_next(wr_ptr_r);
      end
    end
  end

  scs1_ram #(
    .DEPTH (scs1_pkg::RING_DEPTH),
    .WIDTH (scs1_pkg::CHAR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept && do_push),
    .wr_addr (wr_ptr_r),
    .wr_data (act.ch),
    .rd_en   (accept && read_hit),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  // Key code registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cfg_r.left_shift  <= scs1_pkg::LEFT_SHIFT_RST;
      key_cfg_r.right_shift <= scs1_pkg::RIGHT_SHIFT_RST;
      key_cfg_r.caps_key    <= scs1_pkg::CAPS_LOCK_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        scs1_pkg::CFG_LEFT_SHIFT:  key_cfg_r.left_shift  <= cfg_wdata;
        scs1_pkg::CFG_RIGHT_SHIFT: key_cfg_r.right_shift <= cfg_wdata;
        scs1_pkg::CFG_CAPS_LOCK:   key_cfg_r.caps_key    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decoder state and ring pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_held_r <= 1'b0;
      caps_on_r    <= 1'b0;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
    end else begin
      shift_held_r <= shift_held_nxt;
      caps_on_r    <= caps_on_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
    end
  end

  // Read stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Read stage payload, captured with the pointers after this word.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read_valid_r <= read_hit;
      s1_avail_r      <= rd_ptr_nxt != wr_ptr_nxt;
      s1_dropped_r    <= dropped;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Output register payload; the RAM data is valid only for a popped character.
  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid_r) begin
      out_word_r.read_char      <= s1_read_valid_r ? rd_data : '0;
      out_word_r.read_valid     <= s1_read_valid_r;
      out_word_r.data_available <= s1_avail_r;
      out_word_r.char_dropped   <= s1_dropped_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Pushed characters are never zero, so a popped one is never zero either.
  a_pop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.read_valid |-> out_word_r.read_char != '0)
    else $error("popped character is zero");

  // A read never reports a dropped character.
  a_read_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.read_valid && out_word_r.char_dropped))
    else $error("read and drop reported together");

  // A full ring does not advance the write pointer.
  a_full_holds_wp: assert property (@(posedge clk) disable iff (!rst_n)
    ring_full |=> (wr_ptr_r == $past(wr_ptr_r)))
    else $error("write pointer moved into a full ring");

  // Input stalls only while the read stage and the output register both hold a word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

endmodule

// File: tb/scs1_check_pkg.sv
// Key tables and the result scoreboard of the set 1 scancode decoder testbench.
`timescale 1ns / 100ps

package scs1_check_pkg;
  import scs1_pkg::*;

  // Characters for key codes below 64 when shift and caps agree.
  localparam logic [CHAR_W-1:0] KEY_PLAIN [TABLE_SIZE] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Characters for key codes below 64 when shift and caps disagree.
  localparam logic [CHAR_W-1:0] KEY_SHIFTED [TABLE_SIZE] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Tracks modifiers and the character ring, and checks each result word in order.
  class key_ring_scoreboard;
    logic [CODE_W-1:0] left_code;
    logic [CODE_W-1:0] right_code;
    logic [CODE_W-1:0] caps_code;
    bit                shift_held;
    bit                caps_on;
    logic [CHAR_W-1:0] ring [RING_DEPTH];
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    out_word_t         expected_q[$];
    int unsigned       mismatches;
    int unsigned       words_in;
    int unsigned       chars_pushed;
    int unsigned       chars_dropped;
    int unsigned       chars_read;

    function new();
      left_code     = LEFT_SHIFT_RST;
      right_code    = RIGHT_SHIFT_RST;
      caps_code     = CAPS_LOCK_RST;
      shift_held    = 1'b0;
      caps_on       = 1'b0;
      rd_ptr        = 0;
      wr_ptr        = 0;
      mismatches    = 0;
      words_in      = 0;
      chars_pushed  = 0;
      chars_dropped = 0;
      chars_read    = 0;
    endfunction

    // Mirror of one key code register write.
    function void set_key_code(logic [CFG_ADDR_W-1:0] idx, logic [CODE_W-1:0] val);
      case (idx)
        CFG_LEFT_SHIFT:  left_code  = val;
        CFG_RIGHT_SHIFT: right_code = val;
        CFG_CAPS_LOCK:   caps_code  = val;
        default: ;
      endcase
    endfunction

    // Work out the result of one accepted input word and queue it.
    function void note_word(in_word_t w);
      out_word_t         e;
      logic              release_bit;
      logic [CODE_W-1:0] code;
      logic [CHAR_W-1:0] ch;
      int unsigned       nxt;
      e = '0;
      words_in++;
      if (w.func == FUNC_READ) begin
        if (rd_ptr != wr_ptr) begin
          e.read_char  = ring[rd_ptr];
          e.read_valid = 1'b1;
          rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        end
      end else begin
        release_bit = w.scan_byte[7];
        code        = w.scan_byte[6:0];
        // Shift wins over caps lock when both registers hold the same code.
        if (code == left_code || code == right_code) begin
          shift_held = !release_bit;
        end else if (code == caps_code && !release_bit) begin
          caps_on = !caps_on;
        end else if (!release_bit && code < TABLE_SIZE) begin
          ch = (shift_held != caps_on) ? KEY_SHIFTED[code[5:0]] : KEY_PLAIN[code[5:0]];
          if (ch != '0) begin
            nxt = (wr_ptr + 1) % RING_DEPTH;
            if (nxt == rd_ptr) begin
              e.char_dropped = 1'b1;
              chars_dropped++;
            end else begin
              ring[wr_ptr] = ch;
              wr_ptr = nxt;
              chars_pushed++;
            end
          end
        end
      end
      e.data_available = (rd_ptr != wr_ptr);
      expected_q.push_back(e);
    endfunction

    // Compare one accepted result word with the oldest pending expectation.
    function void check_word(out_word_t got);
      out_word_t e;
      bit        bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word: char %h valid %b avail %b drop %b",
                   got.read_char, got.read_valid, got.data_available, got.char_dropped);
        end
        return;
      end
      e = expected_q.pop_front();
      bad = (got.read_char !== e.read_char) || (got.read_valid !== e.read_valid) ||
            (got.data_available !== e.data_available) ||
            (got.char_dropped !== e.char_dropped);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected char %h valid %b avail %b drop %b",
                   e.read_char, e.read_valid, e.data_available, e.char_dropped);
          $display("                 actual   char %h valid %b avail %b drop %b",
                   got.read_char, got.read_valid, got.data_available, got.char_dropped);
        end
      end else if (got.read_valid) begin
        chars_read++;
      end
    endfunction

    function bit idle();
      return expected_q.size() == 0;
    endfunction
  endclass

endpackage

// File: tb/tb_scancode_set1_decoder_fifo.sv
// Top of the testbench: drives scancode and read words and checks every result word.
`timescale 1ns / 100ps

module tb_scancode_set1_decoder_fifo;
  import scs1_pkg::*;
  import scs1_check_pkg::*;

  localparam int CLK_HALF  = 2;
  localparam int LIMIT     = 400000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN     = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CODE_W-1:0]     cfg_wdata;

  key_ring_scoreboard    sb;
  in_word_t              stim_q[$];
  bit                    hold_pending = 1'b0;
  int unsigned           cycles = 0;

  scancode_set1_decoder_fifo u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running clock.
  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check every result word taken by the receiver.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_word(out_word);
    end
  end

  // Receiver: changing stall patterns, plus one long hold-off whenever asked.
  initial begin : receiver
    int unsigned mode;
    int unsigned len;
    int unsigned n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = (mode == 3) ? $urandom_range(1, 10) : $urandom_range(5, 60);
        for (n = 0; n < len; n++) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 40);
            2:       out_stall <= (n % 5 == 4);
            default: out_stall <= 1'b1;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function void push_scan(logic [7:0] b);
    in_word_t w;
    w.func      = FUNC_SCAN;
    w.scan_byte = b;
    stim_q.push_back(w);
  endfunction

  function void push_read(logic [7:0] b);
    in_word_t w;
    w.func      = FUNC_READ;
    w.scan_byte = b;
    stim_q.push_back(w);
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  // Send the queued words in bursts separated by random gaps.
  task automatic drive_words();
    int unsigned burst;
    int unsigned gap;
    while (stim_q.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && stim_q.size() > 0) begin
        send_word(stim_q.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0 || stim_q.size() == 0) begin
        in_valid <= 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    while (!sb.idle()) @(posedge clk);
  endtask

  // Write all three key code registers on back-to-back cycles.
  task automatic write_key_codes(logic [CODE_W-1:0] l, logic [CODE_W-1:0] r,
                                 logic [CODE_W-1:0] c);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_LEFT_SHIFT;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_addr  <= CFG_RIGHT_SHIFT;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_addr  <= CFG_CAPS_LOCK;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_key_code(CFG_LEFT_SHIFT, l);
    sb.set_key_code(CFG_RIGHT_SHIFT, r);
    sb.set_key_code(CFG_CAPS_LOCK, c);
  endtask

  // Mostly typing sequences around the current key codes, with reads and stray bytes.
  task automatic add_random_words(int unsigned n);
    int unsigned       added;
    int unsigned       pick;
    bit                with_shift;
    bit                do_release;
    logic [CODE_W-1:0] sh;
    logic [CODE_W-1:0] key;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        push_read(8'($urandom_range(0, 255)));
        added++;
      end else if (pick < 75) begin
        key        = 7'($urandom_range(1, 63));
        sh         = $urandom_range(0, 1) ? sb.left_code : sb.right_code;
        with_shift = ($urandom_range(0, 99) < 40);
        do_release = ($urandom_range(0, 99) < 70);
        if (with_shift) push_scan({1'b0, sh});
        push_scan({1'b0, key});
        if (do_release) push_scan({1'b1, key});
        if (with_shift) push_scan({1'b1, sh});
        added += 1 + (with_shift ? 2 : 0) + (do_release ? 1 : 0);
      end else if (pick < 85) begin
        push_scan({1'b0, sb.caps_code});
        added++;
        if ($urandom_range(0, 1)) begin
          push_scan({1'b1, sb.caps_code});
          added++;
        end
      end else begin
        push_scan(8'($urandom_range(0, 255)));
        added++;
      end
    end
  endtask

  initial begin
    int unsigned i;
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_LEFT_SHIFT;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset key codes.
    push_read(8'h00);   // read from an empty ring
    push_read(8'hFF);   // read ignores the byte
    push_scan(8'h00);   // key code with an empty table entry
    push_scan(8'h1D);   // another empty entry
    push_scan(8'h01);   // escape
    push_scan(8'h02);   // plain digit
    push_scan(8'h2A);   // left shift make
    push_scan(8'h02);   // shifted digit
    push_scan(8'h10);   // shifted letter
    push_scan(8'hAA);   // left shift release
    push_scan(8'h3A);   // caps lock make toggles caps on
    push_scan(8'h10);   // letter under caps
    push_scan(8'hBA);   // caps release is ignored
    push_scan(8'h36);   // right shift with caps cancels out
    push_scan(8'h10);
    push_scan(8'hB6);   // right shift release
    push_scan(8'h3A);   // caps off again
    push_scan(8'h40);   // first code past the table
    push_scan(8'h7F);   // largest code
    push_scan(8'hFF);   // release of the largest code
    push_scan(8'h9E);   // release of a letter key
    push_scan(8'h39);   // space
    push_scan(8'h3F);   // last table entry, empty
    for (i = 0; i < 4; i++) push_read(8'h00);
    drive_words();
    wait_idle();

    // Extreme key codes, caps lock code beyond the table; long receiver hold-off.
    write_key_codes(7'd0, 7'd127, 7'd100);
    add_random_words(60);
    hold_pending = 1'b1;
    drive_words();
    wait_idle();

    // Caps lock code equal to the right shift code.
    write_key_codes(7'd127, 7'd0, 7'd0);
    add_random_words(60);
    drive_words();
    wait_idle();

    // Reset key codes again: fill the ring past full, read part of it back, then random words.
    write_key_codes(LEFT_SHIFT_RST, RIGHT_SHIFT_RST, CAPS_LOCK_RST);
    for (i = 0; i < 270; i++) push_scan(8'($urandom_range(2, 13)));
    for (i = 0; i < 60; i++) push_read(8'($urandom_range(0, 255)));
    add_random_words(30);
    hold_pending = 1'b1;
    drive_words();
    wait_idle();
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d words over four key code settings, with a full ring and long stalls.",
             sb.words_in);
    $display("Characters queued %0d, dropped %0d, read back %0d.",
             sb.chars_pushed, sb.chars_dropped, sb.chars_read);
    if (sb.mismatches == 0 && sb.idle()) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/scs1_pkg.sv
rtl/core/scs1_ram.sv
rtl/core/scs1_keymap.sv
rtl/core/scancode_set1_decoder_fifo.sv
tb/scs1_check_pkg.sv
tb/tb_scancode_set1_decoder_fifo.sv
